FILE: src/assert_macros.svh
// Shared assertion helpers for the line engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");

`endif

FILE: src/lld_pkg.sv
package lld_pkg;

    // Default grid size
    localparam int LLD_GRID_POINTS = 512;

    // Request kinds carried in tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_CURRENT_DECAY     = 3'd0;
    localparam logic [2:0] CFG_CURRENT_DRIVE     = 3'd1;
    localparam logic [2:0] CFG_VOLTAGE_DRIVE     = 3'd2;
    localparam logic [2:0] CFG_EDGE_KEEP         = 3'd3;
    localparam logic [2:0] CFG_EDGE_DRIVE        = 3'd4;
    localparam logic [2:0] CFG_ARRIVAL_THRESHOLD = 3'd5;

    // Configuration reset values
    localparam logic signed [31:0] RST_CURRENT_DECAY = 32'sd16775941;
    localparam logic signed [31:0] RST_CURRENT_DRIVE = 32'sd318767;
    localparam logic signed [31:0] RST_VOLTAGE_DRIVE = 32'sd796917760;
    localparam logic signed [31:0] RST_EDGE_KEEP     = 32'sd5972000;
    localparam logic signed [31:0] RST_EDGE_DRIVE    = 32'sd540270000;
    localparam logic [30:0]        RST_THRESHOLD     = 31'd268435;

    localparam logic [15:0] STEP_MAX = 16'hFFFF;

    typedef struct packed {
        logic signed [31:0] decay;
        logic signed [31:0] cdrive;
        logic signed [31:0] vdrive;
        logic signed [31:0] ekeep;
        logic signed [31:0] edrive;
        logic [30:0]        thresh;
    } lld_coef_t;

    // End-point operands collected during the sweep
    typedef struct packed {
        logic signed [31:0] v0;
        logic signed [31:0] vn;
        logic signed [31:0] i0;
        logic signed [31:0] in2;
    } lld_edge_in_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_EDGE,
        ST_WRL,
        ST_WRR,
        ST_OUT
    } lld_state_t;

    typedef enum logic [2:0] {
        EG_IDLE,
        EG_MUL_LK,
        EG_MUL_LD,
        EG_MUL_RK,
        EG_MUL_RD,
        EG_ACC,
        EG_DONE
    } lld_edge_st_t;

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Round a Q8.24 product to nearest, ties up
    function automatic logic signed [63:0] rnd24(input logic signed [63:0] p);
        return (p + 64'sd8388608) >>> 24;
    endfunction

    // Round a Q1.17 weighted product to nearest, ties up
    function automatic logic signed [63:0] rnd17(input logic signed [63:0] p);
        return (p + 64'sd65536) >>> 17;
    endfunction

    // Absolute value clamped to 31 bits
    function automatic logic [30:0] mag31(input logic signed [31:0] v);
        logic [30:0] r;
        logic signed [31:0] n;
        n = -v;
        if (v == 32'sh80000000) begin
            r = 31'h7FFFFFFF;
        end else if (v < 0) begin
            r = n[30:0];
        end else begin
            r = v[30:0];
        end
        return r;
    endfunction

endpackage

FILE: src/lossy_line_fdtd_step.sv
// Lossy transmission-line time-step engine. A load item (tuser 0) writes one
// source weight; a step item (tuser 1) sweeps the grid through the voltage,
// current and profile memories one point per cycle, then runs the two
// resistive end updates on a shared multiplier, and yields one result item
// after the read pass, the drain of the ten-stage point pipeline, the end
// updates, two end write-backs and the output load; the next item is taken
// in the following cycle. After reset a clearing pass zeroes voltages and
// currents before the first item is taken; configuration writes are taken at
// any time but must only be made while the block is idle. Source weights must
// be loaded before a step uses them.
`include "assert_macros.svh"

module lossy_line_fdtd_step
    import lld_pkg::*;
#(
    parameter int GRID_POINTS = LLD_GRID_POINTS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [8:0] profile_index, [26:9] profile_weight, [58:27] source_drive
    input  logic [63:0]  s_tdata,
    // [0] req_type
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] left_voltage, [63:32] right_voltage, [64] left_reached,
    // [65] right_reached, [81:66] left_arrival, [97:82] right_arrival,
    // [128:98] peak_magnitude, [144:129] step_number
    output logic [151:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int AW = $clog2(GRID_POINTS);
    localparam int CW = $clog2(GRID_POINTS + 1);
    localparam logic [CW-1:0] K_LAST = CW'(GRID_POINTS);
    localparam logic [AW-1:0] A_LAST = AW'(GRID_POINTS - 1);

    lld_state_t         state_reg, state_next;
    lld_coef_t          coef_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic [CW-1:0]      iss_cnt_reg;
    logic signed [31:0] drive_reg;

    logic               in_acc, step_acc, load_acc;
    logic               iss_valid, edge_start, clr_we, wrl, wrr, out_load;
    logic [AW-1:0]      rd_addr;
    logic [8:0]         in_idx;

    logic               pv_we, pi_we;
    logic [AW-1:0]      pv_waddr, pi_waddr;
    logic signed [31:0] pv_wdata, pi_wdata;
    logic               v_we, i_we, p_we;
    logic [AW-1:0]      v_waddr, i_waddr;
    logic [31:0]        v_wdata, i_wdata, v_rdata, i_rdata;
    logic [17:0]        p_rdata;
    lld_edge_in_t       edge_in;
    logic [30:0]        pipe_peak;
    logic               pipe_busy, edge_done;
    logic signed [31:0] left_v, right_v;

    logic               lflag_reg, rflag_reg;
    logic [15:0]        lstep_reg, rstep_reg, total_reg;
    logic [15:0]        total_next;
    logic [30:0]        lmag, rmag, peak_all;
    logic               lhit, rhit;
    logic               m_valid_reg;
    logic [151:0]       m_data_reg;

    assign in_acc   = s_tvalid && s_tready;
    assign step_acc = in_acc && (s_tuser == REQ_STEP);
    assign load_acc = in_acc && (s_tuser == REQ_LOAD);
    assign in_idx   = s_tdata[8:0];

    // Configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.decay  <= RST_CURRENT_DECAY;
            coef_reg.cdrive <= RST_CURRENT_DRIVE;
            coef_reg.vdrive <= RST_VOLTAGE_DRIVE;
            coef_reg.ekeep  <= RST_EDGE_KEEP;
            coef_reg.edrive <= RST_EDGE_DRIVE;
            coef_reg.thresh <= RST_THRESHOLD;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CURRENT_DECAY:     coef_reg.decay  <= $signed(cfg_data);
                CFG_CURRENT_DRIVE:     coef_reg.cdrive <= $signed(cfg_data);
                CFG_VOLTAGE_DRIVE:     coef_reg.vdrive <= $signed(cfg_data);
                CFG_EDGE_KEEP:         coef_reg.ekeep  <= $signed(cfg_data);
                CFG_EDGE_DRIVE:        coef_reg.edrive <= $signed(cfg_data);
                CFG_ARRIVAL_THRESHOLD: coef_reg.thresh <= cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == A_LAST) state_next = ST_IDLE;
            ST_IDLE:  if (step_acc) state_next = ST_SWEEP;
            ST_SWEEP: if (iss_cnt_reg == K_LAST) state_next = ST_DRAIN;
            ST_DRAIN: if (!pipe_busy) state_next = ST_EDGE;
            ST_EDGE:  if (edge_done) state_next = ST_WRL;
            ST_WRL:   state_next = ST_WRR;
            ST_WRR:   state_next = ST_OUT;
            ST_OUT:   if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready   = 1'b0;
        iss_valid  = 1'b0;
        edge_start = 1'b0;
        clr_we     = 1'b0;
        wrl        = 1'b0;
        wrr        = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_CLEAR: clr_we     = 1'b1;
            ST_IDLE:  s_tready   = 1'b1;
            ST_SWEEP: iss_valid  = 1'b1;
            ST_DRAIN: edge_start = !pipe_busy;
            ST_WRL:   wrl        = 1'b1;
            ST_WRR:   wrr        = 1'b1;
            ST_OUT:   out_load   = !m_valid_reg || m_tready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            iss_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (clr_we) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (step_acc) begin
                iss_cnt_reg <= '0;
            end else if (iss_valid) begin
                iss_cnt_reg <= iss_cnt_reg + 1'b1;
            end
        end
    end

    // Latch the step's source drive
    always_ff @(posedge aclk) begin
        if (step_acc) begin
            drive_reg <= $signed(s_tdata[58:27]);
        end
    end

    assign rd_addr = (iss_cnt_reg == K_LAST) ? '0 : iss_cnt_reg[AW-1:0];

    // Memory write arbitration
    always_comb begin
        v_we    = pv_we;
        v_waddr = pv_waddr;
        v_wdata = pv_wdata;
        if (clr_we) begin
            v_we    = 1'b1;
            v_waddr = clr_cnt_reg;
            v_wdata = '0;
        end else if (wrl) begin
            v_we    = 1'b1;
            v_waddr = '0;
            v_wdata = left_v;
        end else if (wrr) begin
            v_we    = 1'b1;
            v_waddr = A_LAST;
            v_wdata = right_v;
        end
    end

    assign i_we    = clr_we || pi_we;
    assign i_waddr = clr_we ? clr_cnt_reg : pi_waddr;
    assign i_wdata = clr_we ? 32'd0 : pi_wdata;
    assign p_we    = load_acc && (32'(in_idx) < GRID_POINTS);

    lld_ram #(.WIDTH(32), .DEPTH(GRID_POINTS)) u_vmem (
        .aclk  (aclk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (rd_addr),
        .rdata (v_rdata)
    );

    lld_ram #(.WIDTH(32), .DEPTH(GRID_POINTS)) u_imem (
        .aclk  (aclk),
        .we    (i_we),
        .waddr (i_waddr),
        .wdata (i_wdata),
        .raddr (rd_addr),
        .rdata (i_rdata)
    );

    lld_ram #(.WIDTH(18), .DEPTH(GRID_POINTS)) u_pmem (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (AW'(in_idx)),
        .wdata (s_tdata[26:9]),
        .raddr (rd_addr),
        .rdata (p_rdata)
    );

    lld_sweep #(.GRID_POINTS(GRID_POINTS)) u_sweep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (step_acc),
        .iss_valid (iss_valid),
        .iss_idx   (iss_cnt_reg),
        .v_rdata   ($signed(v_rdata)),
        .i_rdata   ($signed(i_rdata)),
        .p_rdata   (p_rdata),
        .coef      (coef_reg),
        .drive     (drive_reg),
        .v_we      (pv_we),
        .v_waddr   (pv_waddr),
        .v_wdata   (pv_wdata),
        .i_we      (pi_we),
        .i_waddr   (pi_waddr),
        .i_wdata   (pi_wdata),
        .edge_in   (edge_in),
        .peak      (pipe_peak),
        .busy      (pipe_busy)
    );

    lld_edge u_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (edge_start),
        .coef    (coef_reg),
        .edge_in (edge_in),
        .done    (edge_done),
        .left    (left_v),
        .right   (right_v)
    );

    // Arrival and peak for the finished step
    assign total_next = (total_reg == STEP_MAX) ? total_reg : total_reg + 1'b1;
    assign lmag       = mag31(left_v);
    assign rmag       = mag31(right_v);
    assign lhit       = lmag >= coef_reg.thresh;
    assign rhit       = rmag >= coef_reg.thresh;

    always_comb begin
        peak_all = pipe_peak;
        if (lmag > peak_all) begin
            peak_all = lmag;
        end
        if (rmag > peak_all) begin
            peak_all = rmag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lflag_reg <= 1'b0;
            rflag_reg <= 1'b0;
            lstep_reg <= '0;
            rstep_reg <= '0;
            total_reg <= '0;
        end else if (out_load) begin
            total_reg <= total_next;
            if (!lflag_reg && lhit) begin
                lflag_reg <= 1'b1;
                lstep_reg <= total_next;
            end
            if (!rflag_reg && rhit) begin
                rflag_reg <= 1'b1;
                rstep_reg <= total_next;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {7'd0, total_next, peak_all,
                           (!rflag_reg && rhit) ? total_next : rstep_reg,
                           (!lflag_reg && lhit) ? total_next : lstep_reg,
                           rflag_reg | rhit, lflag_reg | lhit,
                           right_v, left_v};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `ASSERT_CLK(a_idle_quiet, aclk, aresetn, s_tready |-> !pipe_busy)
    `ASSERT_NEVER(a_no_end_sweep_write, aclk, aresetn,
                  pv_we && (pv_waddr == '0 || pv_waddr == A_LAST))
    `ASSERT_CLK(a_step_starts, aclk, aresetn, step_acc |=> state_reg == ST_SWEEP)

endmodule

FILE: src/lld_ram.sv
module lld_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry registered
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/lld_sweep.sv
module lld_sweep
    import lld_pkg::*;
#(
    parameter int GRID_POINTS = LLD_GRID_POINTS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic                             iss_valid,
    input  logic [$clog2(GRID_POINTS+1)-1:0] iss_idx,
    input  logic signed [31:0]               v_rdata,
    input  logic signed [31:0]               i_rdata,
    input  logic [17:0]                      p_rdata,
    input  lld_coef_t                        coef,
    input  logic signed [31:0]               drive,
    output logic                             v_we,
    output logic [$clog2(GRID_POINTS)-1:0]   v_waddr,
    output logic signed [31:0]               v_wdata,
    output logic                             i_we,
    output logic [$clog2(GRID_POINTS)-1:0]   i_waddr,
    output logic signed [31:0]               i_wdata,
    output lld_edge_in_t                     edge_in,
    output logic [30:0]                      peak,
    output logic                             busy
);

    localparam int AW = $clog2(GRID_POINTS);
    localparam int CW = $clog2(GRID_POINTS + 1);
    localparam logic [CW-1:0] K_LAST = CW'(GRID_POINTS);
    localparam logic [AW-1:0] J_LAST = AW'(GRID_POINTS - 1);
    localparam logic [AW-1:0] J_PEN  = AW'(GRID_POINTS - 2);

    logic              s1_vld_reg;
    logic [CW-1:0]     s1_k_reg;
    logic signed [31:0] pv_reg, pi_reg;
    logic [17:0]       pp_reg;
    logic              emit;
    logic [CW-1:0]     k_dec;
    logic [10:2]       vld_reg;

    logic [AW-1:0]     s2_j_reg, s3_j_reg, s4_j_reg, s5_j_reg, s6_j_reg;
    logic [AW-1:0]     s7_j_reg, s8_j_reg, s9_j_reg, s10_j_reg;
    logic              s2_cur_reg, s3_cur_reg, s4_cur_reg, s5_cur_reg;
    logic signed [31:0] s2_dv_reg, s2_iold_reg, s2_vold_reg;
    logic [17:0]       s2_p_reg;
    logic signed [63:0] s3_pa_reg, s3_pb_reg, s3_ps_reg;
    logic signed [31:0] s3_vold_reg, s4_vold_reg, s5_vold_reg, s6_vold_reg;
    logic signed [31:0] s7_vold_reg, s8_vold_reg;
    logic signed [31:0] s4_a_reg, s4_b_reg;
    logic signed [31:0] s4_src_reg, s5_src_reg, s6_src_reg, s7_src_reg;
    logic signed [31:0] s8_src_reg, s9_src_reg;
    logic signed [31:0] s5_inew_reg, pin_reg, s6_di_reg;
    logic signed [63:0] s7_pv_reg;
    logic signed [31:0] s8_m_reg, s9_v1_reg, s10_v_reg;
    logic [30:0]       peak_reg, s10_mag;
    lld_edge_in_t      edge_reg;

    // Register the issue valid and shift the stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            vld_reg    <= '0;
        end else begin
            s1_vld_reg <= iss_valid;
            vld_reg    <= {vld_reg[9:2], emit};
        end
    end

    assign emit  = s1_vld_reg && (s1_k_reg != '0);
    assign k_dec = s1_k_reg - 1'b1;

    // Advance the point pipeline
    always_ff @(posedge aclk) begin
        s1_k_reg <= iss_idx;
        if (s1_vld_reg) begin
            pv_reg <= v_rdata;
            pi_reg <= i_rdata;
            pp_reg <= p_rdata;
        end
        // voltage difference, old current
        s2_j_reg    <= k_dec[AW-1:0];
        s2_cur_reg  <= (s1_k_reg != K_LAST);
        s2_dv_reg   <= sat32(64'(v_rdata) - 64'(pv_reg));
        s2_iold_reg <= pi_reg;
        s2_vold_reg <= pv_reg;
        s2_p_reg    <= pp_reg;
        // products
        s3_j_reg    <= s2_j_reg;
        s3_cur_reg  <= s2_cur_reg;
        s3_vold_reg <= s2_vold_reg;
        s3_pa_reg   <= $signed(coef.decay) * $signed(s2_iold_reg);
        s3_pb_reg   <= $signed(coef.cdrive) * $signed(s2_dv_reg);
        s3_ps_reg   <= $signed({1'b0, s2_p_reg}) * $signed(drive);
        // round and clamp
        s4_j_reg    <= s3_j_reg;
        s4_cur_reg  <= s3_cur_reg;
        s4_vold_reg <= s3_vold_reg;
        s4_a_reg    <= sat32(rnd24(s3_pa_reg));
        s4_b_reg    <= sat32(rnd24(s3_pb_reg));
        s4_src_reg  <= sat32(rnd17(s3_ps_reg));
        // new current
        s5_j_reg    <= s4_j_reg;
        s5_cur_reg  <= s4_cur_reg;
        s5_vold_reg <= s4_vold_reg;
        s5_src_reg  <= s4_src_reg;
        s5_inew_reg <= sat32(64'(s4_a_reg) - 64'(s4_b_reg));
        if (vld_reg[5]) begin
            pin_reg <= s5_inew_reg;
        end
        // current difference
        s6_j_reg    <= s5_j_reg;
        s6_vold_reg <= s5_vold_reg;
        s6_src_reg  <= s5_src_reg;
        s6_di_reg   <= sat32(64'(s5_inew_reg) - 64'(pin_reg));
        // voltage product
        s7_j_reg    <= s6_j_reg;
        s7_vold_reg <= s6_vold_reg;
        s7_src_reg  <= s6_src_reg;
        s7_pv_reg   <= $signed(coef.vdrive) * $signed(s6_di_reg);
        s8_j_reg    <= s7_j_reg;
        s8_vold_reg <= s7_vold_reg;
        s8_src_reg  <= s7_src_reg;
        s8_m_reg    <= sat32(rnd24(s7_pv_reg));
        s9_j_reg    <= s8_j_reg;
        s9_src_reg  <= s8_src_reg;
        s9_v1_reg   <= sat32(64'(s8_vold_reg) - 64'(s8_m_reg));
        s10_j_reg   <= s9_j_reg;
        s10_v_reg   <= sat32(64'(s9_v1_reg) - 64'(s9_src_reg));
    end

    // Collect end-point operands
    always_ff @(posedge aclk) begin
        if (vld_reg[2] && s2_j_reg == '0) begin
            edge_reg.v0 <= s2_vold_reg;
        end
        if (vld_reg[2] && s2_j_reg == J_LAST) begin
            edge_reg.vn <= s2_vold_reg;
        end
        if (vld_reg[5] && s5_j_reg == '0) begin
            edge_reg.i0 <= s5_inew_reg;
        end
        if (vld_reg[5] && s5_j_reg == J_PEN) begin
            edge_reg.in2 <= s5_inew_reg;
        end
    end

    // Write back currents and interior voltages
    assign i_we    = vld_reg[5] && s5_cur_reg;
    assign i_waddr = s5_j_reg;
    assign i_wdata = s5_inew_reg;
    assign v_we    = vld_reg[10] && (s10_j_reg != '0) && (s10_j_reg != J_LAST);
    assign v_waddr = s10_j_reg;
    assign v_wdata = s10_v_reg;
    assign s10_mag = mag31(s10_v_reg);

    // Track the interior peak
    always_ff @(posedge aclk) begin
        if (!aresetn || start) begin
            peak_reg <= '0;
        end else if (v_we && s10_mag > peak_reg) begin
            peak_reg <= s10_mag;
        end
    end

    assign peak    = peak_reg;
    assign edge_in = edge_reg;
    assign busy    = s1_vld_reg || (|vld_reg);

endmodule

FILE: src/lld_edge.sv
module lld_edge
    import lld_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  lld_coef_t          coef,
    input  lld_edge_in_t       edge_in,
    output logic               done,
    output logic signed [31:0] left,
    output logic signed [31:0] right
);

    lld_edge_st_t       state_reg, state_next;
    logic               mul_en, ta_ld, tb_ld, left_ld, right_ld;
    logic signed [31:0] op_c, op_x, term;
    logic signed [63:0] prod_reg;
    logic signed [31:0] ta_reg, tb_reg, left_reg, right_reg;

    // Step through the four end products
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            EG_IDLE:   if (start) state_next = EG_MUL_LK;
            EG_MUL_LK: state_next = EG_MUL_LD;
            EG_MUL_LD: state_next = EG_MUL_RK;
            EG_MUL_RK: state_next = EG_MUL_RD;
            EG_MUL_RD: state_next = EG_ACC;
            EG_ACC:    state_next = EG_DONE;
            EG_DONE:   state_next = EG_IDLE;
            default:   state_next = EG_IDLE;
        endcase
    end

    // Select operands and loads
    always_comb begin
        mul_en   = 1'b0;
        ta_ld    = 1'b0;
        tb_ld    = 1'b0;
        left_ld  = 1'b0;
        right_ld = 1'b0;
        done     = 1'b0;
        op_c     = coef.ekeep;
        op_x     = edge_in.v0;
        case (state_reg)
            EG_MUL_LK: begin
                mul_en = 1'b1;
            end
            EG_MUL_LD: begin
                mul_en = 1'b1;
                ta_ld  = 1'b1;
                op_c   = coef.edrive;
                op_x   = edge_in.i0;
            end
            EG_MUL_RK: begin
                mul_en = 1'b1;
                tb_ld  = 1'b1;
                op_x   = edge_in.vn;
            end
            EG_MUL_RD: begin
                mul_en  = 1'b1;
                ta_ld   = 1'b1;
                left_ld = 1'b1;
                op_c    = coef.edrive;
                op_x    = edge_in.in2;
            end
            EG_ACC: begin
                tb_ld = 1'b1;
            end
            EG_DONE: begin
                right_ld = 1'b1;
                done     = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign term = sat32(rnd24(prod_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EG_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Multiply, round and combine
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= $signed(op_c) * $signed(op_x);
        end
        if (ta_ld) begin
            ta_reg <= term;
        end
        if (tb_ld) begin
            tb_reg <= term;
        end
        if (left_ld) begin
            left_reg <= sat32(64'(ta_reg) - 64'(tb_reg));
        end
        if (right_ld) begin
            right_reg <= sat32(64'(ta_reg) + 64'(tb_reg));
        end
    end

    assign left  = left_reg;
    assign right = right_reg;

endmodule
